// ===== hw/rtl/assert_macros.svh =====
// Assertion macros used by the scheduler top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked in the same cycle, quiet during reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Implication checked in the next cycle, quiet during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== hw/rtl/rrq_pkg.sv =====
// Package: sizes, codes and item types of the round-robin quantum scheduler.
`timescale 1ns / 1ps
`default_nettype none
package rrq_pkg;

  localparam int MAX_PROCESSES = 16;
  localparam int SLOT_W        = (MAX_PROCESSES > 2) ? $clog2(MAX_PROCESSES) : 1;
  localparam int COUNT_W       = $clog2(MAX_PROCESSES + 1);

  // APB register map
  localparam int PADDR_W = 3;
  localparam logic REG_QUANTUM = 1'b0;
  localparam logic [15:0] QUANTUM_RESET = 16'd4;

  // item modes
  localparam logic MODE_ADD = 1'b0;
  localparam logic MODE_RUN = 1'b1;

  // result status codes
  localparam logic [2:0] ST_ADDED    = 3'd0;
  localparam logic [2:0] ST_RUNNING  = 3'd1;
  localparam logic [2:0] ST_FINISHED = 3'd2;
  localparam logic [2:0] ST_FULL     = 3'd3;
  localparam logic [2:0] ST_IDLE     = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [7:0]  process_id;
    logic [15:0] burst_time;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  served_id;
    logic [15:0] remaining_time;
    logic [31:0] queue_wait;
    logic [31:0] elapsed_total;
    logic        ring_empty;
  } out_item_t;

  // one ring entry as held in the job memory
  typedef struct packed {
    logic [7:0]  id;
    logic [15:0] burst;
    logic [15:0] remaining;
  } job_t;

endpackage
`default_nettype wire

// ===== hw/rtl/rrq_in_if.sv =====
// Interface: input item channel (valid, ready, payload).
`timescale 1ns / 1ps
`default_nettype none
interface rrq_in_if;
  logic              valid;
  logic              ready;
  rrq_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rrq_out_if.sv =====
// Interface: result item channel (valid, ready, payload).
`timescale 1ns / 1ps
`default_nettype none
interface rrq_out_if;
  logic               valid;
  logic               ready;
  rrq_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/rrq_ram.sv =====
// Generic RAM: one write port, one read port with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module rrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int ADDR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1
) (
  input  wire logic                   clk,
  input  wire logic                   we,
  input  wire logic [ADDR_W-1:0]      waddr,
  input  wire logic [WIDTH-1:0]       wdata,
  input  wire logic [ADDR_W-1:0]      raddr,
  output      logic [WIDTH-1:0]       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/round_robin_quantum_scheduler.sv =====
// Top level: round-robin job ring with a fixed time quantum.
//
//  channel   kind        dir  contents
//  request   valid/ready in   mode, process_id, burst_time
//  result    valid/ready out  status, served_id, remaining_time, queue_wait,
//                             elapsed_total, ring_empty
//  apb       APB write   in   time_quantum at byte address 0
//
// Each item goes through S_READ, where the served entry is read from the job and link
// memories (registered read data), then S_EXEC, where it is computed and written back.
// A new item is taken in the same cycle the previous one writes back.
// Reset (rst, synchronous) clears the slot-used bits, cursor, count, total and
// the quantum (to 4); the memories need no clearing pass.
// A held result stalls write-back and the input; one item may still be taken
// and read while the block is idle, its write-back then waits for the result.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"
module round_robin_quantum_scheduler (
  input  wire logic                          clk,
  input  wire logic                          rst,
  rrq_in_if.sink                             request,
  rrq_out_if.source                          result,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [rrq_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready
);

  localparam int MAXP    = rrq_pkg::MAX_PROCESSES;
  localparam int SLOT_W  = rrq_pkg::SLOT_W;
  localparam int COUNT_W = rrq_pkg::COUNT_W;
  localparam int JOB_W   = $bits(rrq_pkg::job_t);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_EXEC = 2'd2;

  logic [1:0]          state;
  rrq_pkg::in_item_t   item;
  logic [SLOT_W-1:0]   cursor_slot, next_slot, add_slot, free_slot;
  logic [COUNT_W-1:0]  job_count;
  logic [31:0]         time_sum;
  logic [15:0]         time_quantum;
  logic [MAXP-1:0]     slot_used;
  logic                out_valid;
  rrq_pkg::out_item_t  out_data;

  // memory ports
  logic                job_we, link_we;
  logic [SLOT_W-1:0]   job_waddr, link_waddr;
  rrq_pkg::job_t       job_wdata, job_rdata;
  logic [SLOT_W-1:0]   link_wdata, link_rdata;
  logic [JOB_W-1:0]    job_rbits;

  // handshake
  logic out_free, in_fire, exec_fire, table_full, add_go;

  assign out_free   = !out_valid || result.ready;
  assign request.ready = !rst && ((state == S_IDLE) || ((state == S_EXEC) && out_free));
  assign in_fire    = request.valid && request.ready;
  assign exec_fire  = (state == S_EXEC) && out_free;
  assign table_full = (job_count == COUNT_W'(MAXP));
  assign add_go     = (item.mode == rrq_pkg::MODE_ADD) && !table_full;

  assign result.valid = out_valid;
  assign result.data  = out_data;

  // APB register
  assign pready = 1'b1;
  assign prdata = (paddr[2] == rrq_pkg::REG_QUANTUM) ? {16'd0, time_quantum} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      time_quantum <= rrq_pkg::QUANTUM_RESET;
    end else if (psel && penable && pwrite && pready
                 && (paddr[2] == rrq_pkg::REG_QUANTUM)) begin
      time_quantum <= pwdata[15:0];
    end
  end

  // lowest unused slot
  always_comb begin
    free_slot = '0;
    for (int i = MAXP - 1; i >= 0; i--) begin
      if (!slot_used[i]) free_slot = SLOT_W'(i);
    end
  end

  // memories: both read at the slot after the cursor
  rrq_ram #(.WIDTH(JOB_W), .DEPTH(MAXP)) u_job_ram (
    .clk(clk), .we(job_we), .waddr(job_waddr), .wdata(job_wdata),
    .raddr(next_slot), .rdata(job_rbits)
  );
  assign job_rdata = rrq_pkg::job_t'(job_rbits);

  rrq_ram #(.WIDTH(SLOT_W), .DEPTH(MAXP)) u_link_ram (
    .clk(clk), .we(link_we), .waddr(link_waddr), .wdata(link_wdata),
    .raddr(next_slot), .rdata(link_rdata)
  );

  // slice arithmetic on the served entry
  logic        finish;
  logic [15:0] served;
  logic [32:0] sum;
  logic [31:0] total_sat, wait_time;

  always_comb begin
    finish    = job_rdata.remaining <= time_quantum;
    served    = finish ? job_rdata.remaining : time_quantum;
    sum       = {1'b0, time_sum} + 33'(served);
    total_sat = sum[32] ? 32'hFFFF_FFFF : sum[31:0];
    wait_time = (total_sat >= 32'(job_rdata.burst)) ? total_sat - 32'(job_rdata.burst) : 32'd0;
  end

  // write-back and next state of the ring
  logic [COUNT_W-1:0] count_next;
  logic [SLOT_W-1:0]  cursor_next, next_slot_next;
  logic [31:0]        total_next;
  logic               set_used, clr_used;
  rrq_pkg::out_item_t out_next;

  always_comb begin
    job_we         = 1'b0;
    job_waddr      = next_slot;
    job_wdata      = job_rdata;
    link_we        = 1'b0;
    link_waddr     = cursor_slot;
    link_wdata     = add_slot;
    count_next     = job_count;
    cursor_next    = cursor_slot;
    next_slot_next = next_slot;
    total_next     = time_sum;
    set_used       = 1'b0;
    clr_used       = 1'b0;
    out_next       = '0;

    if (state == S_READ && add_go) begin
      // new entry goes in its free slot, linked to the cursor's successor
      job_we          = 1'b1;
      job_waddr       = free_slot;
      job_wdata.id    = item.process_id;
      job_wdata.burst = item.burst_time;
      job_wdata.remaining = item.burst_time;
      link_we         = 1'b1;
      link_waddr      = free_slot;
      link_wdata      = (job_count == '0) ? free_slot : next_slot;
    end

    if (state == S_EXEC) begin
      if (item.mode == rrq_pkg::MODE_ADD) begin
        out_next.served_id = item.process_id;
        if (table_full) begin
          out_next.status = rrq_pkg::ST_FULL;
        end else begin
          out_next.status         = rrq_pkg::ST_ADDED;
          out_next.remaining_time = item.burst_time;
          set_used       = 1'b1;
          count_next     = job_count + COUNT_W'(1);
          next_slot_next = add_slot;
          if (job_count == '0) begin
            cursor_next = add_slot;
          end else begin
            link_we    = exec_fire;
            link_waddr = cursor_slot;
            link_wdata = add_slot;
          end
        end
      end else if (job_count == '0) begin
        out_next.status = rrq_pkg::ST_IDLE;
      end else begin
        out_next.served_id = job_rdata.id;
        total_next = total_sat;
        job_we     = exec_fire;
        job_waddr  = next_slot;
        if (finish) begin
          out_next.status       = rrq_pkg::ST_FINISHED;
          out_next.queue_wait   = wait_time;
          job_wdata.remaining   = 16'd0;
          clr_used = 1'b1;
          if (next_slot == cursor_slot) begin
            count_next = '0;
          end else begin
            count_next     = job_count - COUNT_W'(1);
            next_slot_next = link_rdata;
            link_we        = exec_fire;
            link_waddr     = cursor_slot;
            link_wdata     = link_rdata;
          end
        end else begin
          out_next.status         = rrq_pkg::ST_RUNNING;
          out_next.remaining_time = job_rdata.remaining - time_quantum;
          job_wdata.remaining     = job_rdata.remaining - time_quantum;
          cursor_next    = next_slot;
          next_slot_next = link_rdata;
        end
      end
    end

    out_next.elapsed_total = total_next;
    out_next.ring_empty    = (count_next == '0);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (in_fire) state <= S_READ;
        S_READ:  state <= S_EXEC;
        S_EXEC:  if (exec_fire) state <= in_fire ? S_READ : S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // captured item and chosen slot
  always_ff @(posedge clk) begin
    if (in_fire) item <= request.data;
    if (state == S_READ) add_slot <= free_slot;
  end

  // ring control state
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_slot <= '0;
      next_slot   <= '0;
      job_count   <= '0;
      time_sum    <= '0;
      slot_used   <= '0;
    end else if (exec_fire) begin
      cursor_slot <= cursor_next;
      next_slot   <= next_slot_next;
      job_count   <= count_next;
      time_sum    <= total_next;
      if (set_used) slot_used[add_slot] <= 1'b1;
      if (clr_used) slot_used[next_slot] <= 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (exec_fire) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (exec_fire) out_data <= out_next;
  end

  // checks
  `ASSERT_IMPL(a_count_matches_used, clk, rst, 1'b1, $countones(slot_used) == int'(job_count))
  `ASSERT_NEXT(a_accept_starts_read, clk, rst, in_fire, state == S_READ)
  `ASSERT_IMPL(a_idle_means_empty, clk, rst,
               out_valid && (out_data.status == rrq_pkg::ST_IDLE), out_data.ring_empty)

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
// Testbench for the round-robin quantum scheduler: directed and random items, self-checking.
`timescale 1ns / 1ps
module tb;

  localparam int REG_SPARE = 1;  // first unmapped register index
  localparam logic [rrq_pkg::PADDR_W-1:0] ADDR_QUANTUM =
    rrq_pkg::PADDR_W'(4 * rrq_pkg::REG_QUANTUM);
  localparam logic [rrq_pkg::PADDR_W-1:0] ADDR_SPARE   = rrq_pkg::PADDR_W'(4 * REG_SPARE);
  localparam int TIMEOUT_NS    = 40_000_000;
  localparam int DRAIN_CYCLES  = 6;
  localparam int MAX_REPORTED  = 10;
  localparam int MAXP          = rrq_pkg::MAX_PROCESSES;
  localparam int SLOT_W        = rrq_pkg::SLOT_W;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [rrq_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  rrq_in_if  req_if ();
  rrq_out_if res_if ();

  round_robin_quantum_scheduler u_top (
    .clk     (clk),
    .rst     (rst),
    .request (req_if),
    .result  (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // scheduler image: ring of jobs, cursor, count, total, quantum
  logic [7:0]        ring_id     [MAXP];
  logic [15:0]       ring_burst  [MAXP];
  logic [15:0]       ring_left   [MAXP];
  logic [SLOT_W-1:0] ring_next   [MAXP];
  bit                ring_used   [MAXP];
  logic [SLOT_W-1:0] cursor;
  int                job_count;
  logic [31:0]       total_served;
  logic [15:0]       quantum;

  rrq_pkg::out_item_t slice_reports_q[$];
  int        mismatch_count = 0;
  int        tx_idle_pct = 0;
  int        rx_idle_pct = 0;

  // clock
  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("*** FAILED ***");
    $finish;
  end

  function automatic void note_mismatch(string what, logic [63:0] want, logic [63:0] got);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTED)
      $display("mismatch %s: expected %0h, got %0h", what, want, got);
  endfunction

  // saturating add to the served total
  function automatic void add_served(logic [31:0] amt);
    if (total_served > 32'hFFFF_FFFF - amt) total_served = 32'hFFFF_FFFF;
    else total_served = total_served + amt;
  endfunction

  // one item against the ring image: returns the report it causes
  function automatic rrq_pkg::out_item_t ring_step(rrq_pkg::in_item_t it);
    rrq_pkg::out_item_t r;
    int s;
    int t;
    logic [15:0] left;
    r = '0;
    if (it.mode == rrq_pkg::MODE_ADD) begin
      s = 0;
      while (s < MAXP && ring_used[s]) s++;
      if (job_count >= MAXP || s >= MAXP) begin
        r.status    = rrq_pkg::ST_FULL;
        r.served_id = it.process_id;
      end else begin
        ring_id[s]    = it.process_id;
        ring_burst[s] = it.burst_time;
        ring_left[s]  = it.burst_time;
        ring_used[s]  = 1'b1;
        if (job_count == 0) begin
          ring_next[s] = SLOT_W'(s);
          cursor       = SLOT_W'(s);
        end else begin
          ring_next[s]      = ring_next[cursor];
          ring_next[cursor] = SLOT_W'(s);
        end
        job_count++;
        r.status         = rrq_pkg::ST_ADDED;
        r.served_id      = it.process_id;
        r.remaining_time = it.burst_time;
      end
    end else if (job_count == 0) begin
      r.status = rrq_pkg::ST_IDLE;
    end else begin
      t = ring_next[cursor];
      left = ring_left[t];
      r.served_id = ring_id[t];
      if (left <= quantum) begin
        // job finishes and leaves the ring, cursor stays
        add_served(32'(left));
        r.queue_wait = (total_served >= 32'(ring_burst[t])) ?
                       total_served - 32'(ring_burst[t]) : 32'd0;
        ring_left[t] = '0;
        ring_used[t] = 1'b0;
        if (SLOT_W'(t) == cursor) job_count = 0;
        else begin
          ring_next[cursor] = ring_next[t];
          job_count--;
        end
        r.status = rrq_pkg::ST_FINISHED;
      end else begin
        ring_left[t] = left - quantum;
        add_served(32'(quantum));
        cursor = SLOT_W'(t);
        r.status         = rrq_pkg::ST_RUNNING;
        r.remaining_time = ring_left[t];
      end
    end
    r.elapsed_total = total_served;
    r.ring_empty    = (job_count == 0);
    return r;
  endfunction

  function automatic rrq_pkg::in_item_t make_req(logic mode, logic [7:0] id, logic [15:0] burst);
    rrq_pkg::in_item_t it;
    it.mode       = mode;
    it.process_id = id;
    it.burst_time = burst;
    return it;
  endfunction

  function automatic rrq_pkg::in_item_t random_request(int add_pct);
    logic [15:0] burst;
    case ($urandom_range(9))
      0:       burst = '0;
      1:       burst = 16'($urandom);
      default: burst = 16'($urandom_range(1, 40));
    endcase
    return make_req(($urandom_range(99) < add_pct) ? rrq_pkg::MODE_ADD : rrq_pkg::MODE_RUN,
                    8'($urandom_range(255)), burst);
  endfunction

  function automatic logic [31:0] pick_quantum();
    logic [15:0] q;
    case ($urandom_range(9))
      0:       q = '0;
      1:       q = 16'hFFFF;
      2:       q = 16'($urandom);
      default: q = 16'($urandom_range(1, 12));
    endcase
    // junk in the upper half now and then
    return {($urandom_range(1) == 0) ? 16'h0 : 16'($urandom), q};
  endfunction

  // present one item, wait for it to be taken, record its report
  task automatic push_request(rrq_pkg::in_item_t it);
    while ($urandom_range(99) < tx_idle_pct) begin
      req_if.valid <= 1'b0;
      @(posedge clk);
    end
    req_if.valid <= 1'b1;
    req_if.data  <= it;
    @(posedge clk);
    while (!req_if.ready) @(posedge clk);
    slice_reports_q.push_back(ring_step(it));
  endtask

  // wait until every report is in and the block has gone quiet
  task automatic settle();
    req_if.valid <= 1'b0;
    @(posedge clk);
    while (slice_reports_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // APB write, then read the quantum back
  task automatic write_quantum_reg(logic [rrq_pkg::PADDR_W-1:0] addr, logic [31:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (addr == ADDR_QUANTUM) quantum = value[15:0];
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_QUANTUM;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata !== {16'h0, quantum}) note_mismatch("quantum readback", {16'h0, quantum}, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // result checker
  always @(posedge clk) begin : result_check
    rrq_pkg::out_item_t want;
    if (!rst && res_if.valid && res_if.ready) begin
      if (slice_reports_q.size() == 0) begin
        note_mismatch("unexpected result", '0, 64'(res_if.data));
      end else begin
        want = slice_reports_q.pop_front();
        if (res_if.data.status !== want.status)
          note_mismatch("status", want.status, res_if.data.status);
        if (res_if.data.served_id !== want.served_id)
          note_mismatch("served_id", want.served_id, res_if.data.served_id);
        if (res_if.data.remaining_time !== want.remaining_time)
          note_mismatch("remaining_time", want.remaining_time, res_if.data.remaining_time);
        if (res_if.data.queue_wait !== want.queue_wait)
          note_mismatch("queue_wait", want.queue_wait, res_if.data.queue_wait);
        if (res_if.data.elapsed_total !== want.elapsed_total)
          note_mismatch("elapsed_total", want.elapsed_total, res_if.data.elapsed_total);
        if (res_if.data.ring_empty !== want.ring_empty)
          note_mismatch("ring_empty", want.ring_empty, res_if.data.ring_empty);
      end
    end
  end

  // receiver back-pressure
  always @(posedge clk) begin
    res_if.ready <= ($urandom_range(99) >= rx_idle_pct);
  end

  // reset value of the quantum, empty ring, ids and bursts at their extremes
  task automatic test_directed_basics();
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));   // nothing to run
    push_request(make_req(rrq_pkg::MODE_ADD, 8'h00, 16'h0001));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    push_request(make_req(rrq_pkg::MODE_ADD, 8'hFF, 16'hFFFF));
    push_request(make_req(rrq_pkg::MODE_ADD, 8'hA5, 16'h0000));   // zero burst
    push_request(make_req(rrq_pkg::MODE_RUN, 8'hFF, 16'hFFFF));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h5A, 16'h5A5A));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
  endtask

  // zero and full-scale quantum, write to an unmapped register
  task automatic test_quantum_extremes();
    settle();
    write_quantum_reg(ADDR_QUANTUM, 32'h0);
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));   // served 0, continues
    push_request(make_req(rrq_pkg::MODE_ADD, 8'h5A, 16'h0000));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));   // zero left finishes
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    settle();
    write_quantum_reg(ADDR_QUANTUM, 32'hFFFF_FFFF);
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    settle();
    write_quantum_reg(ADDR_SPARE, 32'h0000_0007);
    push_request(make_req(rrq_pkg::MODE_ADD, 8'h3C, 16'h8000));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    settle();
    write_quantum_reg(ADDR_QUANTUM, 32'h1);
    push_request(make_req(rrq_pkg::MODE_ADD, 8'hC3, 16'h0002));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
  endtask

  // fill every slot, offer one more, then free and reuse slots
  task automatic test_full_table();
    int i;
    settle();
    write_quantum_reg(ADDR_QUANTUM, 32'h3);
    for (i = 0; i <= MAXP; i++)
      push_request(make_req(rrq_pkg::MODE_ADD, 8'(i * 17), 16'(i % 5)));
    for (i = 0; i < 4; i++) push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    push_request(make_req(rrq_pkg::MODE_ADD, 8'h77, 16'h0009));
  endtask

  // random mix of adds and runs, quantum changed between chunks
  task automatic test_random_traffic(int tx_pct, int rx_pct, int n_items);
    int sent;
    int chunk;
    int add_pct;
    int i;
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      settle();
      write_quantum_reg(ADDR_QUANTUM, pick_quantum());
      case ($urandom_range(2))
        0:       add_pct = 30;
        1:       add_pct = 50;
        default: add_pct = 70;
      endcase
      chunk = $urandom_range(30, 50);
      for (i = 0; i < chunk; i++) push_request(random_request(add_pct));
      sent += chunk;
    end
  endtask

  // full-size jobs served back to back at full-scale quantum
  task automatic test_full_size_jobs();
    int k;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    settle();
    write_quantum_reg(ADDR_QUANTUM, 32'hFFFF);
    for (k = 0; k <= MAXP; k++) push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    // each add is served right away: the new job sits after the cursor
    for (k = 0; k < 8; k++) begin
      push_request(make_req(rrq_pkg::MODE_ADD, 8'(k), 16'hFFFF));
      push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
    end
    push_request(make_req(rrq_pkg::MODE_ADD, 8'h11, 16'h0005));
    push_request(make_req(rrq_pkg::MODE_RUN, 8'h00, 16'h0000));
  endtask

  // main sequence
  initial begin
    rst          <= 1'b1;
    psel         <= 1'b0;
    penable      <= 1'b0;
    pwrite       <= 1'b0;
    paddr        <= '0;
    pwdata       <= '0;
    req_if.valid <= 1'b0;
    req_if.data  <= '0;
    for (int i = 0; i < MAXP; i++) ring_used[i] = 1'b0;
    cursor       = '0;
    job_count    = 0;
    total_served = '0;
    quantum      = rrq_pkg::QUANTUM_RESET;
    tx_idle_pct  = 34;
    rx_idle_pct  = 79;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_directed_basics();
    test_quantum_extremes();
    test_full_table();
    test_random_traffic(34, 79, 240);
    test_random_traffic(79, 34, 240);
    test_random_traffic(0, 0, 240);
    test_full_size_jobs();
    settle();

    if (mismatch_count == 0 && slice_reports_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
